>>> hw/rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, constants and helper functions for the UV sphere vertex
// generator and its divider and CORDIC pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  localparam int GRID_BITS       = 10;
  localparam int COORD_FRAC_BITS = 8;
  localparam int RADIUS_W        = 16;
  localparam int POS_W           = 17;
  localparam int TEX_W           = 16;
  localparam int CORNER_W        = 2 * GRID_BITS + 1;

  // Angles are in units of 2^-16 turn.
  localparam int ANGLE_W   = 16;
  localparam int DIV_STEPS = ANGLE_W + 1;
  localparam int NUM_W     = GRID_BITS + DIV_STEPS;

  localparam int TRIG_W        = 32;
  localparam int TRIG_ONE_BITS = 30;
  localparam int ZW            = ANGLE_W + 2;
  localparam int CORDIC_STEPS  = 14;
  localparam int CORDIC_LAT    = CORDIC_STEPS + 2;

  localparam int PROD_W = 50;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 32'sh26DD3B6A;
  localparam logic signed [ZW-1:0]     QUARTER_TURN    = ZW'(1 << (ANGLE_W - 2));
  localparam logic signed [ZW-1:0]     HALF_TURN       = ZW'(1 << (ANGLE_W - 1));

  localparam logic [RADIUS_W-1:0]  RADIUS_RESET = RADIUS_W'(1 << COORD_FRAC_BITS);
  localparam logic [GRID_BITS-1:0] RING_RESET   = GRID_BITS'(16);
  localparam logic [GRID_BITS-1:0] SECTOR_RESET = GRID_BITS'(32);
  localparam logic [TEX_W:0]       TEX_QUARTER  = (TEX_W + 1)'(1 << (TEX_W - 2));
  localparam int                   POS_LIMIT    = 65535;

  typedef enum logic [1:0] {
    REG_RADIUS       = 2'd0,
    REG_RING_COUNT   = 2'd1,
    REG_SECTOR_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                in_range;
    logic                quad;
    logic [CORNER_W-1:0] corner_this;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
  } side_t;

  // Arctangent of 2^-i in 2^-16 turn units.
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = ZW'(8192);
      1:       a = ZW'(4836);
      2:       a = ZW'(2555);
      3:       a = ZW'(1297);
      4:       a = ZW'(651);
      5:       a = ZW'(326);
      6:       a = ZW'(163);
      7:       a = ZW'(81);
      8:       a = ZW'(41);
      9:       a = ZW'(20);
      10:      a = ZW'(10);
      11:      a = ZW'(5);
      12:      a = ZW'(3);
      13:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round half up by 2^30, then clamp to the coordinate range.
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + (PROD_W'(1) <<< (TRIG_ONE_BITS - 1))) >>> TRIG_ONE_BITS;
    if (r > PROD_W'(POS_LIMIT)) begin
      r = PROD_W'(POS_LIMIT);
    end else if (r < -PROD_W'(POS_LIMIT)) begin
      r = -PROD_W'(POS_LIMIT);
    end
    return r[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage. The upper part of
// the numerator must already be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_div
  import uvs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [GRID_BITS-1:0] divisor,
  input  wire logic [NUM_W-1:0]     numer,
  output logic      [DIV_STEPS-1:0] quot
);

  logic [GRID_BITS-1:0] rem_q [DIV_STEPS-1];
  logic [DIV_STEPS-1:0] low_q [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [GRID_BITS-1:0] rem_in;
    logic [DIV_STEPS-1:0] low_in;
    logic [GRID_BITS:0]   trial;
    logic                 take;

    if (i == 0) begin : g_first
      assign rem_in = numer[NUM_W-1:DIV_STEPS];
      assign low_in = numer[DIV_STEPS-1:0];
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
    end

    assign trial = {rem_in, low_in[DIV_STEPS-1]};
    assign take  = trial >= {1'b0, divisor};

    // Numerator bits shift out at the top while quotient bits shift in below.
    always_ff @(posedge clk) begin
      if (en) begin
        low_q[i] <= {low_in[DIV_STEPS-2:0], take};
      end
    end

    if (i < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? GRID_BITS'(trial - {1'b0, divisor}) : trial[GRID_BITS-1:0];
        end
      end
    end
  end

  assign quot = low_q[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> hw/rtl/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation CORDIC: quadrant fold, one iteration per stage, then the
// sign fix for folded angles. Results are Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cordic
  import uvs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [ANGLE_W-1:0]       angle,
  output logic signed [TRIG_W-1:0]      sine,
  output logic signed [TRIG_W-1:0]      cosine
);

  logic signed [ZW-1:0]     z_wrap;
  logic signed [ZW-1:0]     z_fold;
  logic                     neg_fold;
  logic signed [ZW-1:0]     z0;
  logic                     neg0;
  logic signed [TRIG_W-1:0] x_q [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0]     z_q [CORDIC_STEPS];
  logic                     neg_q [CORDIC_STEPS];

  // Bring the angle into a quarter turn either side of zero.
  always_comb begin
    z_wrap   = ZW'($signed(angle));
    z_fold   = z_wrap;
    neg_fold = 1'b0;
    if (z_wrap > QUARTER_TURN) begin
      z_fold   = z_wrap - HALF_TURN;
      neg_fold = 1'b1;
    end else if (z_wrap < -QUARTER_TURN) begin
      z_fold   = z_wrap + HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0   <= z_fold;
      neg0 <= neg_fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [TRIG_W-1:0] x_in;
    logic signed [TRIG_W-1:0] y_in;
    logic signed [ZW-1:0]     z_in;
    logic                     neg_in;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;

    if (i == 0) begin : g_first
      assign x_in   = CORDIC_GAIN_INV;
      assign y_in   = '0;
      assign z_in   = z0;
      assign neg_in = neg0;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        neg_q[i] <= neg_in;
        if (!z_in[ZW-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - atan_turn(i);
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine   <= neg_q[CORDIC_STEPS-1] ? -y_q[CORDIC_STEPS-1] : y_q[CORDIC_STEPS-1];
      cosine <= neg_q[CORDIC_STEPS-1] ? -x_q[CORDIC_STEPS-1] : x_q[CORDIC_STEPS-1];
    end
  end

  // The residual angle of the last iteration is not needed.
  logic unused_z;
  assign unused_z = ^z_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

>>> hw/rtl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position, texture coordinates and quad corner indices of one UV sphere
// grid point per beat.
// ----------------------------------------------------------------------------
//   channel  handshake           payload
//   in       in_valid/in_stall   ring_index, sector_index
//   out      out_valid/out_stall point_in_range, pos_x/y/z, tex_u/v,
//                                quad_valid, corner_this, corner_below
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat is taken every cycle unless stalled, through the input register, a
// 17-stage divider, a 16-stage CORDIC, three multiply stages and the output
// register. Synchronous reset clears the valid bits, sets config defaults. An
// output stall with out_valid high freezes the pipeline and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [GRID_BITS-1:0]        ring_index,
  input  wire logic [GRID_BITS-1:0]        sector_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             point_in_range,
  output logic signed [POS_W-1:0]          pos_x,
  output logic signed [POS_W-1:0]          pos_y,
  output logic signed [POS_W-1:0]          pos_z,
  output logic [TEX_W-1:0]                 tex_u,
  output logic [TEX_W-1:0]                 tex_v,
  output logic                             quad_valid,
  output logic [CORNER_W-1:0]              corner_this,
  output logic [CORNER_W-1:0]              corner_below,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [RADIUS_W-1:0]         cfg_data
);

  localparam int TEX_AT = DIV_STEPS + 1;
  localparam int LAST   = DIV_STEPS + CORDIC_LAT + 3;

  logic [RADIUS_W-1:0]  radius;
  logic [GRID_BITS-1:0] ring_count;
  logic [GRID_BITS-1:0] sector_count;
  logic                 en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RESET;
      ring_count   <= RING_RESET;
      sector_count <= SECTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_RADIUS:       radius       <= cfg_data;
        REG_RING_COUNT:   ring_count   <= cfg_data[GRID_BITS-1:0];
        REG_SECTOR_COUNT: sector_count <= cfg_data[GRID_BITS-1:0];
        default:          ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Input stage: range checks, corner index and the three numerators.
  logic                 in_range_c;
  logic                 quad_c;
  side_t                side0_c;
  logic [NUM_W-1:0]     num_theta;
  logic [NUM_W-1:0]     num_u;
  logic [NUM_W-1:0]     num_v;
  logic [NUM_W-1:0]     num_theta_c;
  logic [NUM_W-1:0]     num_u_c;
  logic [NUM_W-1:0]     num_v_c;

  always_comb begin
    in_range_c = (ring_count != '0) && (sector_count != '0) &&
                 (ring_index <= ring_count) && (sector_index <= sector_count);
    quad_c     = in_range_c && (ring_index < ring_count) && (sector_index < sector_count);
    side0_c          = '0;
    side0_c.in_range = in_range_c;
    side0_c.quad     = quad_c;
    if (quad_c) begin
      side0_c.corner_this = CORNER_W'(ring_index * ({1'b0, sector_count} + 1'b1))
                          + CORNER_W'(sector_index);
    end
    num_theta_c = (NUM_W'(sector_index) << ANGLE_W) + NUM_W'(sector_count >> 1);
    num_u_c     = (NUM_W'(sector_index) << (ANGLE_W - 1)) + NUM_W'(sector_count >> 1);
    num_v_c     = (NUM_W'(ring_index) << (ANGLE_W - 1)) + NUM_W'(ring_count >> 1);
  end

  logic  vld  [LAST+1];
  side_t side [LAST+1];

  always_ff @(posedge clk) begin
    if (en) begin
      num_theta <= num_theta_c;
      num_u     <= num_u_c;
      num_v     <= num_v_c;
    end
  end

  logic [DIV_STEPS-1:0] q_theta;
  logic [DIV_STEPS-1:0] q_u;
  logic [DIV_STEPS-1:0] q_v;

  uvs_div u_div_theta (
    .clk     (clk),
    .en      (en),
    .divisor (sector_count),
    .numer   (num_theta),
    .quot    (q_theta)
  );

  uvs_div u_div_u (
    .clk     (clk),
    .en      (en),
    .divisor (sector_count),
    .numer   (num_u),
    .quot    (q_u)
  );

  uvs_div u_div_v (
    .clk     (clk),
    .en      (en),
    .divisor (ring_count),
    .numer   (num_v),
    .quot    (q_v)
  );

  // Valid bits and side data ride alongside the arithmetic; the texture
  // coordinates join once the quotients are out of the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  side_t side_tex_c;

  always_comb begin
    side_tex_c       = side[TEX_AT-1];
    side_tex_c.tex_u = side[TEX_AT-1].in_range ?
                       TEX_W'(TEX_QUARTER + {1'b0, q_u[TEX_W-1:0]}) : '0;
    side_tex_c.tex_v = side[TEX_AT-1].in_range ?
                       TEX_W'(TEX_QUARTER + {1'b0, q_v[TEX_W-1:0]}) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side0_c;
      for (int k = 1; k <= LAST; k++) begin
        side[k] <= (k == TEX_AT) ? side_tex_c : side[k-1];
      end
    end
  end

  logic signed [TRIG_W-1:0] sin_t;
  logic signed [TRIG_W-1:0] cos_t;
  logic signed [TRIG_W-1:0] sin_p;
  logic signed [TRIG_W-1:0] cos_p;

  uvs_cordic u_cordic_theta (
    .clk    (clk),
    .en     (en),
    .angle  (q_theta[ANGLE_W-1:0]),
    .sine   (sin_t),
    .cosine (cos_t)
  );

  uvs_cordic u_cordic_phi (
    .clk    (clk),
    .en     (en),
    .angle  (q_v[ANGLE_W-1:0]),
    .sine   (sin_p),
    .cosine (cos_p)
  );

  // Multiply stages.
  logic signed [RADIUS_W:0]     radius_s;
  logic signed [2*TRIG_W-1:0]   prod_x;
  logic signed [2*TRIG_W-1:0]   prod_z;
  logic signed [PROD_W-1:0]     prod_y;
  logic signed [TRIG_W-1:0]     t_x;
  logic signed [TRIG_W-1:0]     t_z;
  logic signed [POS_W-1:0]      y_m2;
  logic signed [PROD_W-1:0]     prod2_x;
  logic signed [PROD_W-1:0]     prod2_z;
  logic signed [POS_W-1:0]      y_m3;
  logic signed [2*TRIG_W-1:0]   half_lsb;

  assign radius_s = $signed({1'b0, radius});
  assign half_lsb = (2*TRIG_W)'(1) <<< (TRIG_ONE_BITS - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x  <= sin_p * cos_t;
      prod_z  <= sin_p * sin_t;
      prod_y  <= PROD_W'(radius_s * (-(TRIG_W + 1)'(cos_p)));
      t_x     <= TRIG_W'((prod_x + half_lsb) >>> TRIG_ONE_BITS);
      t_z     <= TRIG_W'((prod_z + half_lsb) >>> TRIG_ONE_BITS);
      y_m2    <= round_sat(prod_y);
      prod2_x <= PROD_W'(radius_s * t_x);
      prod2_z <= PROD_W'(radius_s * t_z);
      y_m3    <= y_m2;
    end
  end

  // Output register; fields are zero for points off the grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_in_range <= side[LAST].in_range;
      pos_x          <= side[LAST].in_range ? round_sat(prod2_x) : '0;
      pos_y          <= side[LAST].in_range ? y_m3 : '0;
      pos_z          <= side[LAST].in_range ? round_sat(prod2_z) : '0;
      tex_u          <= side[LAST].tex_u;
      tex_v          <= side[LAST].tex_v;
      quad_valid     <= side[LAST].quad;
      corner_this    <= side[LAST].corner_this;
      corner_below   <= side[LAST].quad ?
                        CORNER_W'(side[LAST].corner_this + CORNER_W'(sector_count) + 1'b1) :
                        '0;
    end
  end

endmodule

`default_nettype wire
